@@ src/tkc_pkg.sv @@
// ----------------------------------------------------------------------------
// tkc_pkg
// Shared types, keyword tables and direction codes for the turn keyword
// classifier.
// ----------------------------------------------------------------------------
package tkc_pkg;

  localparam int unsigned NUM_KW   = 25;
  localparam int unsigned KW_MAX   = 11;
  localparam int unsigned PROG_W   = 4;
  localparam int unsigned KW_BITS  = KW_MAX * 8;

  typedef logic [PROG_W-1:0] prog_t;
  typedef logic [NUM_KW-1:0] kw_vec_t;

  // keyword text, right aligned: last character in the low byte
  localparam logic [KW_BITS-1:0] KW_TEXT [NUM_KW] = '{
    "wenden", "u-turn", "umkehren",
    "ziel", "destination", "arrive", "angekommen",
    "scharf", "rechts", "links",
    "sharp", "right", "left",
    "leicht", "slight", "halten", "keep", "bear",
    "geradeaus", "straight", "weiter", "continue", "head", "folgen", "follow"
  };

  localparam prog_t KW_LEN [NUM_KW] = '{
    4'd6, 4'd6, 4'd8,
    4'd4, 4'd11, 4'd6, 4'd10,
    4'd6, 4'd6, 4'd5,
    4'd5, 4'd5, 4'd4,
    4'd6, 4'd6, 4'd6, 4'd4, 4'd4,
    4'd9, 4'd8, 4'd6, 4'd8, 4'd4, 4'd6, 4'd6
  };

  // keyword indexes used by the priority rules
  localparam int unsigned KW_WENDEN      = 0;
  localparam int unsigned KW_UTURN       = 1;
  localparam int unsigned KW_UMKEHREN    = 2;
  localparam int unsigned KW_ZIEL        = 3;
  localparam int unsigned KW_DESTINATION = 4;
  localparam int unsigned KW_ARRIVE      = 5;
  localparam int unsigned KW_ANGEKOMMEN  = 6;
  localparam int unsigned KW_SCHARF      = 7;
  localparam int unsigned KW_RECHTS      = 8;
  localparam int unsigned KW_LINKS       = 9;
  localparam int unsigned KW_SHARP       = 10;
  localparam int unsigned KW_RIGHT       = 11;
  localparam int unsigned KW_LEFT        = 12;
  localparam int unsigned KW_LEICHT      = 13;
  localparam int unsigned KW_SLIGHT      = 14;
  localparam int unsigned KW_HALTEN      = 15;
  localparam int unsigned KW_KEEP        = 16;
  localparam int unsigned KW_BEAR        = 17;
  localparam int unsigned KW_GERADEAUS   = 18;
  localparam int unsigned KW_STRAIGHT    = 19;
  localparam int unsigned KW_WEITER      = 20;
  localparam int unsigned KW_CONTINUE    = 21;
  localparam int unsigned KW_HEAD        = 22;
  localparam int unsigned KW_FOLGEN      = 23;
  localparam int unsigned KW_FOLLOW      = 24;

  typedef enum logic [3:0] {
    DIR_UNKNOWN      = 4'd0,
    DIR_STRAIGHT     = 4'd1,
    DIR_SLIGHT_RIGHT = 4'd2,
    DIR_RIGHT        = 4'd3,
    DIR_SHARP_RIGHT  = 4'd4,
    DIR_UTURN        = 4'd5,
    DIR_SHARP_LEFT   = 4'd6,
    DIR_LEFT         = 4'd7,
    DIR_SLIGHT_LEFT  = 4'd8,
    DIR_DESTINATION  = 4'd9
  } dir_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       no_byte;
    logic       end_of_text;
  } item_t;

  localparam logic [7:0] ASCII_UP_A = 8'h41;
  localparam logic [7:0] ASCII_UP_Z = 8'h5A;
  localparam logic [7:0] ASCII_LO_A = 8'h61;
  localparam logic [7:0] ASCII_LO_Z = 8'h7A;
  localparam logic [7:0] ASCII_MAX  = 8'h7F;
  localparam logic [7:0] CASE_BIT   = 8'h20;

  // character p of keyword k, zero past the end
  function automatic logic [7:0] kw_char(input int unsigned k, input prog_t p);
    prog_t pos;
    pos = KW_LEN[k] - 4'd1 - p;
    if (p >= KW_LEN[k]) begin
      return 8'h00;
    end
    return KW_TEXT[k][{pos, 3'b000} +: 8];
  endfunction

endpackage

@@ src/tkc_in_stage.sv @@
// ----------------------------------------------------------------------------
// tkc_in_stage
// Input register: holds one item until the match stage takes it.
// ----------------------------------------------------------------------------
module tkc_in_stage
  import tkc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_byte
  input  logic        s_tuser,   // [0] no_byte
  input  logic        s_tlast,   // end_of_text
  input  logic        take,
  output logic        item_valid,
  output item_t       item
);

  assign s_tready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.char_byte   <= s_tdata;
      item.no_byte     <= s_tuser;
      item.end_of_text <= s_tlast;
    end
  end

endmodule

@@ src/tkc_match_bank.sv @@
// ----------------------------------------------------------------------------
// tkc_match_bank
// Per-keyword progress counters and found flags, all updated together from the
// same byte; gives the final found vector for the closing item.
// ----------------------------------------------------------------------------
module tkc_match_bank
  import tkc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  output kw_vec_t found_final
);

  logic       prev_is_letter;
  prog_t      progress [NUM_KW];
  kw_vec_t    found;

  logic [7:0] folded;
  logic       letter;
  logic       byte_in;
  prog_t      progress_upd [NUM_KW];
  kw_vec_t    found_upd;
  kw_vec_t    complete;

  assign byte_in = !item.no_byte;

  always_comb begin
    folded = item.char_byte;
    if (item.char_byte >= ASCII_UP_A && item.char_byte <= ASCII_UP_Z) begin
      folded = item.char_byte | CASE_BIT;
    end
    letter = (folded >= ASCII_LO_A && folded <= ASCII_LO_Z) || (folded > ASCII_MAX);
  end

  for (genvar g = 0; g < NUM_KW; g++) begin : g_kw
    logic  done;
    prog_t np;

    assign done = progress[g] >= KW_LEN[g];

    always_comb begin
      np = '0;
      if (!done && folded == kw_char(g, progress[g]) &&
          (progress[g] != '0 || !prev_is_letter)) begin
        np = progress[g] + 4'd1;
      end
      // a fresh start at a word boundary
      if (np == '0 && !prev_is_letter && folded == kw_char(g, '0)) begin
        np = 4'd1;
      end
    end

    assign progress_upd[g] = byte_in ? np : progress[g];
    assign found_upd[g]    = found[g] || (byte_in && done && !letter);
    assign complete[g]     = progress_upd[g] >= KW_LEN[g];
  end

  // end of text is a boundary too
  assign found_final = found_upd | complete;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_is_letter <= 1'b0;
      found          <= '0;
      for (int i = 0; i < NUM_KW; i++) begin
        progress[i] <= '0;
      end
    end else if (fire) begin
      if (item.end_of_text) begin
        prev_is_letter <= 1'b0;
        found          <= '0;
        for (int i = 0; i < NUM_KW; i++) begin
          progress[i] <= '0;
        end
      end else begin
        if (byte_in) begin
          prev_is_letter <= letter;
        end
        found <= found_upd;
        for (int i = 0; i < NUM_KW; i++) begin
          progress[i] <= progress_upd[i];
        end
      end
    end
  end

endmodule

@@ src/tkc_classify.sv @@
// ----------------------------------------------------------------------------
// tkc_classify
// Priority rules that turn the found keyword flags into one direction.
// ----------------------------------------------------------------------------
module tkc_classify
  import tkc_pkg::*;
(
  input  kw_vec_t found,
  output dir_t    direction
);

  logic uturn_w;
  logic dest_w;
  logic slight_w;
  logic straight_w;
  logic right_w;
  logic left_w;

  always_comb begin
    uturn_w    = found[KW_WENDEN] || found[KW_UTURN] || found[KW_UMKEHREN];
    dest_w     = found[KW_ZIEL] || found[KW_DESTINATION] || found[KW_ARRIVE] ||
                 found[KW_ANGEKOMMEN];
    slight_w   = found[KW_LEICHT] || found[KW_SLIGHT] || found[KW_HALTEN] ||
                 found[KW_KEEP] || found[KW_BEAR];
    straight_w = found[KW_GERADEAUS] || found[KW_STRAIGHT] || found[KW_WEITER] ||
                 found[KW_CONTINUE] || found[KW_HEAD] || found[KW_FOLGEN] ||
                 found[KW_FOLLOW];
    right_w    = found[KW_RECHTS] || found[KW_RIGHT];
    left_w     = found[KW_LINKS] || found[KW_LEFT];

    if (uturn_w) begin
      direction = DIR_UTURN;
    end else if (dest_w) begin
      direction = DIR_DESTINATION;
    end else if (found[KW_SCHARF] && found[KW_RECHTS]) begin
      direction = DIR_SHARP_RIGHT;
    end else if (found[KW_SCHARF] && found[KW_LINKS]) begin
      direction = DIR_SHARP_LEFT;
    end else if (found[KW_SHARP] && found[KW_RIGHT]) begin
      direction = DIR_SHARP_RIGHT;
    end else if (found[KW_SHARP] && found[KW_LEFT]) begin
      direction = DIR_SHARP_LEFT;
    end else if (slight_w && right_w) begin
      direction = DIR_SLIGHT_RIGHT;
    end else if (slight_w && left_w) begin
      direction = DIR_SLIGHT_LEFT;
    end else if (right_w) begin
      direction = DIR_RIGHT;
    end else if (left_w) begin
      direction = DIR_LEFT;
    end else if (straight_w) begin
      direction = DIR_STRAIGHT;
    end else begin
      direction = DIR_UNKNOWN;
    end
  end

endmodule

@@ src/turn_keyword_classifier_top.sv @@
// ----------------------------------------------------------------------------
// turn_keyword_classifier_top
// Spots 25 navigation keywords as whole words in a byte stream and gives
// one direction code for each text.
//
//   channel  dir  tdata                    tuser       tlast
//   s_*      in   [7:0] char_byte          [0] no_byte end_of_text
//   m_*      out  [3:0] direction, 0 pad   -           -
//
// one item per cycle unless a closing item waits on a stalled output; the match logic works on the input register, so a
// closing item's direction is registered at the output as the item is taken
// all 25 matchers check the same byte in parallel in a single stage
// rst clears the match state; each closing item returns it to that state
// a stalled output holds back closing items and the items behind them; other items keep flowing
// ----------------------------------------------------------------------------
module turn_keyword_classifier_top
  import tkc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_byte
  input  logic       s_tuser,   // [0] no_byte
  input  logic       s_tlast,   // end_of_text
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [3:0] direction, [7:4] zero
);

  logic    item_valid;
  item_t   item;
  logic    fire;
  kw_vec_t found_final;
  dir_t    dir_comb;
  dir_t    dir_reg;

  // closing items need a free output slot
  assign fire = item_valid && (!item.end_of_text || !m_tvalid || m_tready);

  tkc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  tkc_match_bank u_match (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .item        (item),
    .found_final (found_final)
  );

  tkc_classify u_class (
    .found     (found_final),
    .direction (dir_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire && item.end_of_text) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && item.end_of_text) begin
      dir_reg <= dir_comb;
    end
  end

  assign m_tdata = {4'b0000, dir_reg};

endmodule
